// ===== hw/rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and block layout constants.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;
   localparam int unsigned BLOCK_DEPTH = 16;          // block words of 32 bits
   localparam logic [7:0]  PAD_BYTE    = 8'h80;
   localparam int unsigned LEN_OFFSET  = 56;

   function automatic logic [31:0] init_word(input logic [2:0] i);
      logic [31:0] r;
      begin
         case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
         endcase
         return r;
      end
   endfunction

   localparam logic [31:0] K_TAB [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
endpackage
`default_nettype wire

// ===== hw/rtl/sha256_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs 64 rounds over the block held in a word memory. Rounds 0 to 15 read
// the block words from that memory; later schedule words roll through a
// 16-word register window.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   output      logic        done,
   // block word writes from the collector while idle
   input  wire logic        wr_en,
   input  wire logic [3:0]  wr_addr,
   input  wire logic [31:0] wr_data,
   input  wire logic        h_init,
   input  wire logic [2:0]  h_rd_idx,
   output      logic [31:0] h_rd_data
);
   logic [31:0] wmem [sha256_pkg::BLOCK_DEPTH];
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] r_ff [8];
   logic [31:0] r_in [8];
   logic [31:0] win_ff [16];   // shadow window for schedule taps
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, fin_ff, fin_in;
   logic [31:0] rd_q;

   // memory read port: word i of this round, registered
   always_ff @(posedge clock) begin
      if (wr_en) wmem[wr_addr] <= wr_data;
      rd_q <= wmem[cnt_in[3:0]];
   end

   function automatic logic [31:0] ror(input logic [31:0] v, input int k);
      return (v >> k) | (v << (32 - k));
   endfunction

   logic [31:0] w, a15, a2, t1, t2, e, a;
   logic [5:0]  ri;
   always_comb begin
      ri  = cnt_ff[5:0];
      a15 = win_ff[4'(ri + 6'd1)];
      a2  = win_ff[4'(ri + 6'd14)];
      if (ri < 6'd16) w = rd_q;
      else w = win_ff[ri[3:0]] + (ror(a15,7) ^ ror(a15,18) ^ (a15 >> 3))
               + win_ff[4'(ri + 6'd9)] + (ror(a2,17) ^ ror(a2,19) ^ (a2 >> 10));
      e  = r_ff[4];
      a  = r_ff[0];
      t1 = r_ff[7] + (ror(e,6) ^ ror(e,11) ^ ror(e,25)) + ((e & r_ff[5]) ^ (~e & r_ff[6]))
           + sha256_pkg::K_TAB[ri] + w;
      t2 = (ror(a,2) ^ ror(a,13) ^ ror(a,22)) + ((a & r_ff[1]) ^ (a & r_ff[2]) ^ (r_ff[1] & r_ff[2]));
      r_in = r_ff;
      h_in = h_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      fin_in = 1'b0;
      if (start && !run_ff) begin
         run_in = 1'b1;
         cnt_in = '0;
         r_in = h_ff;
      end else if (run_ff) begin
         r_in[7] = r_ff[6]; r_in[6] = r_ff[5]; r_in[5] = r_ff[4];
         r_in[4] = r_ff[3] + t1;
         r_in[3] = r_ff[2]; r_in[2] = r_ff[1]; r_in[1] = r_ff[0];
         r_in[0] = t1 + t2;
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
      if (fin_ff)
         for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + r_ff[i];
      if (h_init)
         for (int i = 0; i < 8; i++) h_in[i] = sha256_pkg::init_word(3'(i));
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      if (run_ff) win_ff[ri[3:0]] <= w;
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         cnt_ff <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sha256_pkg::init_word(3'(i));
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
         cnt_ff <= cnt_in;
         h_ff   <= h_in;
      end
   end

   assign busy = run_ff | fin_ff;
   assign done = fin_ff;
   assign h_rd_data = h_ff[h_rd_idx];

   a_fin_after_last: assert property (@(posedge clock) disable iff (reset)
      (run_ff && cnt_ff == 7'd63) |=> fin_ff) else $error("no finish pulse");
   a_no_wr_busy: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> !wr_en) else $error("block write during rounds");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> cnt_ff < 7'd64) else $error("round count out of range");
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte stream in, eight digest words out per message.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  req_    | in        | data_byte, has_byte, is_last
//  rsp_    | out       | digest_word, word_index, last_word
// One byte per cycle while req_ready is high; the 64th byte of a block holds
// the input during compression (64 rounds, one per cycle, and the chaining update).
// A last item adds padding word writes and one or two compressions, then
// eight digest words, each held until taken.
// Reset clears counters and loads the initial hash values at once.
// req_ready stays low while a block compresses, padding is written or digest
// words are pending.
`default_nettype none
module sha256_stream_hasher_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_is_last,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [31:0] rsp_digest_word,
   output      logic [2:0]  rsp_word_index,
   output      logic        rsp_last_word
);
   localparam logic [2:0] S_IDLE = 3'd0, S_COMP = 3'd1, S_PAD = 3'd2,
                          S_PCOMP = 3'd3, S_OUT = 3'd4;
   logic [2:0]  st_ff, st_in;
   logic [63:0] bits_ff, bits_in, lenb_ff, lenb_in;
   logic [23:0] acc_ff, acc_in;
   logic [3:0]  pw_ff, pw_in;      // pad word position
   logic        final_ff, final_in; // pending compression is the last one
   logic [2:0]  oi_ff, oi_in;
   logic        wr_en, start, h_init;
   logic [3:0]  wr_addr;
   logic [31:0] wr_data;
   logic        core_busy, core_done;
   logic [31:0] h_rd;
   logic        acc_ok;
   logic [5:0]  pos;
   // pad bookkeeping: whether the length needs a second block
   logic        two_blk_ff, second_ff, pad_pending, pad_done_ff;

   sha256_core u_core (
      .clock(clock), .reset(reset), .start(start), .busy(core_busy), .done(core_done),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data), .h_init(h_init),
      .h_rd_idx(oi_ff), .h_rd_data(h_rd));

   assign req_ready = (st_ff == S_IDLE);
   assign acc_ok = req_valid && req_ready;
   assign pos = bits_ff[8:3];

   always_comb begin
      st_in = st_ff; bits_in = bits_ff; lenb_in = lenb_ff; acc_in = acc_ff;
      pw_in = pw_ff; final_in = final_ff; oi_in = oi_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0; start = 1'b0; h_init = 1'b0;
      case (st_ff)
         S_IDLE: if (acc_ok) begin
            logic [63:0] nb;
            logic [5:0]  np;
            nb = bits_ff;
            if (req_has_byte) begin
               wr_en = (pos[1:0] == 2'd3);
               wr_addr = pos[5:2];
               wr_data = {acc_ff, req_data_byte};
               acc_in = {acc_ff[15:0], req_data_byte};
               nb = bits_ff + 64'd8;
            end
            bits_in = nb;
            np = nb[8:3];
            if (req_has_byte && pos == 6'd63) begin
               start = 1'b1;
               st_in = S_COMP;
               final_in = 1'b0;
            end
            if (req_is_last) begin
               lenb_in = nb;
               final_in = 1'b1;
               st_in = (req_has_byte && pos == 6'd63) ? S_COMP : S_PAD;
               // last data byte shifted into the partial word; the pad byte is added in S_PAD
               acc_in = (req_has_byte ? {acc_ff[15:0], req_data_byte} : acc_ff);
               pw_in = np[5:2];
            end
         end
         S_COMP: if (core_done) begin
            if (final_ff) begin
               st_in = S_PAD;
               pw_in = bits_ff[8:5] == 4'd0 ? 4'd0 : pw_ff;
            end else st_in = S_IDLE;
         end
         S_PAD: begin
            logic [5:0] lp;
            logic [31:0] wd;
            lp = lenb_ff[8:3];
            wd = '0;
            // word holding the pad byte
            if (pw_ff == lp[5:2] && pad_pending)
               case (lp[1:0])
                  2'd0: wd = {sha256_pkg::PAD_BYTE, 24'd0};
                  2'd1: wd = {acc_ff[7:0], sha256_pkg::PAD_BYTE, 16'd0};
                  2'd2: wd = {acc_ff[15:0], sha256_pkg::PAD_BYTE, 8'd0};
                  default: wd = {acc_ff[23:0], sha256_pkg::PAD_BYTE};
               endcase
            if (!two_blk_ff || second_ff) begin
               if (pw_ff == 4'd14) wd = lenb_ff[63:32];
               if (pw_ff == 4'd15) wd = lenb_ff[31:0];
            end
            wr_en = 1'b1; wr_addr = pw_ff; wr_data = wd;
            pw_in = pw_ff + 4'd1;
            if (pw_ff == 4'd15) begin
               start = 1'b1;
               st_in = S_PCOMP;
            end
         end
         S_PCOMP: if (core_done) begin
            if (two_blk_ff && !second_ff) begin
               st_in = S_PAD; pw_in = '0;
            end else begin
               st_in = S_OUT; oi_in = '0;
            end
         end
         S_OUT: if (rsp_ready) begin
            oi_in = oi_ff + 3'd1;
            if (oi_ff == 3'd7) begin
               st_in = S_IDLE; h_init = 1'b1; bits_in = '0; final_in = 1'b0;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign pad_pending = !pad_done_ff;
   always_ff @(posedge clock) begin
      if (reset || st_ff == S_IDLE) begin
         pad_done_ff <= 1'b0;
         second_ff   <= 1'b0;
      end else if (st_ff == S_PAD) begin
         if (pw_ff == lenb_ff[8:5] && !pad_done_ff) pad_done_ff <= 1'b1;
      end else if (st_ff == S_PCOMP && core_done && two_blk_ff) begin
         // first of two pad blocks done, the length block follows
         second_ff <= 1'b1;
      end
      if (st_ff == S_IDLE) two_blk_ff <= (bits_in[8:3] >= 6'd56);
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; lenb_ff <= lenb_in;
      if (reset) begin
         st_ff <= S_IDLE; bits_ff <= '0; pw_ff <= '0; final_ff <= 1'b0; oi_ff <= '0;
      end else begin
         st_ff <= st_in; bits_ff <= bits_in; pw_ff <= pw_in; final_ff <= final_in;
         oi_ff <= oi_in;
      end
   end

   assign rsp_valid = (st_ff == S_OUT);
   assign rsp_digest_word = h_rd;
   assign rsp_word_index = oi_ff;
   assign rsp_last_word = (oi_ff == 3'd7);

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      core_busy |-> !req_ready) else $error("input taken during rounds");
   a_out_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=> rsp_valid) else $error("digest gap");
   a_reset_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> bits_ff == 64'd0) else $error("no clear");
endmodule
`default_nettype wire
